[design/gsa_pkg.sv]
// Shared types and constants of the grouped sum and average block.
`timescale 1ns / 1ps
`default_nettype none
package gsa_pkg;

  localparam int NumGroups = 512;
  localparam int GroupW    = 9;
  localparam int AddrW     = $clog2(NumGroups);
  localparam int FracBits  = 8;
  // widest numerator: 44-bit temperature magnitude shifted by the fraction bits
  localparam int DivW      = 44 + FracBits;
  localparam int DivCntW   = $clog2(DivW + 1);

  typedef struct packed {
    logic               req_type;
    logic [8:0]         group_id;
    logic               delayed_flag;
    logic [9:0]         concurrent_count;
    logic signed [7:0]  vehicle_age;
    logic signed [11:0] temperature_tenths;
    logic [10:0]        wind_tenths;
  } in_t;

  typedef struct packed {
    logic [8:0]         out_group;
    logic [31:0]        record_total;
    logic [31:0]        delayed_total;
    logic [14:0]        delay_rate_q8;
    logic [17:0]        avg_concurrent_q8;
    logic [14:0]        avg_age_q8;
    logic signed [19:0] avg_temperature_q8;
    logic [18:0]        avg_wind_q8;
  } out_t;

  typedef struct packed {
    logic [31:0]        count;
    logic [31:0]        delayed;
    logic [41:0]        conc_sum;
    logic [38:0]        age_sum;
    logic [31:0]        age_count;
    logic signed [43:0] temp_sum;
    logic [42:0]        wind_sum;
  } row_t;

  localparam int RowW = $bits(row_t);

  localparam logic req_accum = 1'b0;
  localparam logic req_read  = 1'b1;

  typedef enum logic [2:0] {
    DivRate = 3'd0,
    DivConc = 3'd1,
    DivAge  = 3'd2,
    DivTemp = 3'd3,
    DivWind = 3'd4
  } div_sel_e;

endpackage
`default_nettype wire

[design/gsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

[design/gsa_div.sv]
// Restoring divider, one quotient bit per cycle; zero divisor gives zero.
`timescale 1ns / 1ps
`default_nettype none
module gsa_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [gsa_pkg::DivW-1:0] num_i,
  input  wire logic [31:0]              den_i,
  output      logic                     done_o,
  output      logic [gsa_pkg::DivW-1:0] quo_o
);
  logic [gsa_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [gsa_pkg::DivW-1:0]    num_q, num_d;
  logic [31:0]                 rem_q, rem_d;
  logic [31:0]                 den_q, den_d;
  logic [32:0]                 rem_sh;
  logic [32:0]                 diff;
  logic                        ge;

  assign rem_sh = {rem_q, num_q[gsa_pkg::DivW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = gsa_pkg::DivCntW'(gsa_pkg::DivW);
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == gsa_pkg::DivCntW'(1));
      rem_d  = ge ? diff[31:0] : rem_sh[31:0];
      num_d  = {num_q[gsa_pkg::DivW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = (den_q == '0) ? '0 : num_q;
endmodule
`default_nettype wire

[design/gsa_front.sv]
// Front end: four-entry item queue between the input port and the back end.
`timescale 1ns / 1ps
`default_nettype none
module gsa_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gsa_pkg::in_t  data_i,
  output      logic          full_o,
  output      logic          valid_o,
  output      gsa_pkg::in_t  data_o,
  input  wire logic          pop_i
);
  gsa_pkg::in_t mem_q [4];
  logic [1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [2:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 2'd1 : wr_q;
    rd_d  = pop_i ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {2'b0, push_i} - {2'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

[design/gsa_back.sv]
// Back end: group table, update and read-out sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none
module gsa_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire gsa_pkg::in_t  item_i,
  output      logic          item_pop_o,
  output      logic          clearing_o,
  output      logic          empty_o,
  input  wire logic          pop_i,
  output      gsa_pkg::out_t out_o
);
  typedef enum logic [6:0] {
    SClear   = 7'b0000001,
    SIdle    = 7'b0000010,
    SRead    = 7'b0000100,
    SRow     = 7'b0001000,
    SDivGo   = 7'b0010000,
    SDivWait = 7'b0100000,
    SOut     = 7'b1000000
  } state_e;

  state_e                     state_q, state_d;
  logic [gsa_pkg::AddrW-1:0]  clr_q, clr_d;
  gsa_pkg::div_sel_e          sel_q, sel_d;
  logic                       out_valid_q, out_valid_d;
  gsa_pkg::out_t              out_q, out_d, res_q, res_d;
  gsa_pkg::in_t               item_q, item_d;
  gsa_pkg::row_t              row_q, row_d, rd_row, nxt_row;

  logic                       ram_we, ram_re;
  logic [gsa_pkg::AddrW-1:0]  ram_waddr;
  logic [gsa_pkg::RowW-1:0]   ram_wdata, ram_rdata;

  logic                       div_start, div_done;
  logic [gsa_pkg::DivW-1:0]   div_num, div_quo;
  logic [31:0]                div_den;
  logic [38:0]                rate_prod;
  logic                       temp_neg;
  logic [43:0]                temp_mag;
  logic [gsa_pkg::DivW-1:0]   temp_q;

  logic [42:0]                conc_sum;
  logic [39:0]                age_sum;
  logic signed [44:0]         temp_sum;
  logic [43:0]                wind_sum;
  logic                       in_range;

  gsa_ram #(.Width(gsa_pkg::RowW), .Depth(gsa_pkg::NumGroups)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (item_q.group_id[gsa_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  gsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign rd_row   = gsa_pkg::row_t'(ram_rdata);
  assign in_range = ({1'b0, item_i.group_id} <
                     (gsa_pkg::GroupW + 1)'(gsa_pkg::NumGroups));

  // saturating row update
  always_comb begin
    nxt_row       = rd_row;
    nxt_row.count = (&rd_row.count) ? rd_row.count : rd_row.count + 32'd1;
    if (item_q.delayed_flag && !(&rd_row.delayed)) begin
      nxt_row.delayed = rd_row.delayed + 32'd1;
    end
    conc_sum         = {1'b0, rd_row.conc_sum} + 43'(item_q.concurrent_count);
    nxt_row.conc_sum = conc_sum[42] ? '1 : conc_sum[41:0];
    age_sum          = {1'b0, rd_row.age_sum} + 40'(item_q.vehicle_age[6:0]);
    if (!item_q.vehicle_age[7]) begin
      nxt_row.age_sum = age_sum[39] ? '1 : age_sum[38:0];
      if (!(&rd_row.age_count)) begin
        nxt_row.age_count = rd_row.age_count + 32'd1;
      end
    end
    temp_sum = 45'(rd_row.temp_sum) + 45'(item_q.temperature_tenths);
    if (temp_sum[44] != temp_sum[43]) begin
      nxt_row.temp_sum = temp_sum[44] ? {1'b1, 43'd0} : {1'b0, {43{1'b1}}};
    end else begin
      nxt_row.temp_sum = temp_sum[43:0];
    end
    wind_sum         = {1'b0, rd_row.wind_sum} + 44'(item_q.wind_tenths);
    nxt_row.wind_sum = wind_sum[43] ? '1 : wind_sum[42:0];
  end

  // divider operand select
  always_comb begin
    rate_prod = 39'(row_q.delayed) * 39'd100;
    temp_neg  = row_q.temp_sum[43];
    temp_mag  = temp_neg ? 44'(-row_q.temp_sum) : 44'(row_q.temp_sum);
    div_den   = row_q.count;
    unique case (sel_q)
      gsa_pkg::DivRate: div_num = gsa_pkg::DivW'(rate_prod) << gsa_pkg::FracBits;
      gsa_pkg::DivConc: div_num = gsa_pkg::DivW'(row_q.conc_sum) << gsa_pkg::FracBits;
      gsa_pkg::DivAge: begin
        div_num = gsa_pkg::DivW'(row_q.age_sum) << gsa_pkg::FracBits;
        div_den = row_q.age_count;
      end
      gsa_pkg::DivTemp: div_num = gsa_pkg::DivW'(temp_mag) << gsa_pkg::FracBits;
      gsa_pkg::DivWind: div_num = gsa_pkg::DivW'(row_q.wind_sum) << gsa_pkg::FracBits;
      default:          div_num = '0;
    endcase
    temp_q = (div_quo > gsa_pkg::DivW'(20'h80000)) ? gsa_pkg::DivW'(20'h80000) : div_quo;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    sel_d       = sel_q;
    res_d       = res_q;
    item_d      = item_q;
    row_d       = row_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~pop_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = item_q.group_id[gsa_pkg::AddrW-1:0];
    ram_wdata   = nxt_row;
    div_start   = 1'b0;
    item_pop_o  = 1'b0;
    unique case (state_q)
      SClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == gsa_pkg::AddrW'(gsa_pkg::NumGroups - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (item_valid_i) begin
          item_pop_o      = 1'b1;
          item_d          = item_i;
          res_d           = '0;
          res_d.out_group = item_i.group_id;
          if (in_range) begin
            state_d = SRead;
          end else if (item_i.req_type == gsa_pkg::req_read) begin
            state_d = SOut;
          end
        end
      end
      SRead: begin
        ram_re  = 1'b1;
        state_d = SRow;
      end
      SRow: begin
        if (item_q.req_type == gsa_pkg::req_accum) begin
          ram_we  = 1'b1;
          state_d = SIdle;
        end else begin
          row_d               = rd_row;
          res_d.record_total  = rd_row.count;
          res_d.delayed_total = rd_row.delayed;
          sel_d               = gsa_pkg::DivRate;
          state_d             = SDivGo;
        end
      end
      SDivGo: begin
        div_start = 1'b1;
        state_d   = SDivWait;
      end
      SDivWait: begin
        if (div_done) begin
          unique case (sel_q)
            gsa_pkg::DivRate: res_d.delay_rate_q8 =
                (div_quo > gsa_pkg::DivW'(15'h7fff)) ? 15'h7fff : div_quo[14:0];
            gsa_pkg::DivConc: res_d.avg_concurrent_q8 =
                (div_quo > gsa_pkg::DivW'(18'h3ffff)) ? 18'h3ffff : div_quo[17:0];
            gsa_pkg::DivAge: res_d.avg_age_q8 =
                (div_quo > gsa_pkg::DivW'(15'h7fff)) ? 15'h7fff : div_quo[14:0];
            gsa_pkg::DivTemp: begin
              if (temp_neg) begin
                res_d.avg_temperature_q8 = 20'(-temp_q[19:0]);
              end else begin
                res_d.avg_temperature_q8 =
                    (div_quo > gsa_pkg::DivW'(19'h7ffff)) ? 20'h7ffff : 20'(div_quo[18:0]);
              end
            end
            gsa_pkg::DivWind: res_d.avg_wind_q8 =
                (div_quo > gsa_pkg::DivW'(19'h7ffff)) ? 19'h7ffff : div_quo[18:0];
            default: ;
          endcase
          if (sel_q == gsa_pkg::DivWind) begin
            state_d = SOut;
          end else begin
            sel_d   = gsa_pkg::div_sel_e'(sel_q + 3'd1);
            state_d = SDivGo;
          end
        end
      end
      SOut: begin
        if (!out_valid_q || pop_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      sel_q       <= gsa_pkg::DivRate;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    item_q <= item_d;
    row_q  <= row_d;
    out_q  <= out_d;
  end

  assign clearing_o = (state_q == SClear);
  assign empty_o    = ~out_valid_q;
  assign out_o      = out_q;
endmodule
`default_nettype wire

[design/grouped_sum_and_average.sv]
// Top level of the grouped sum and average block.
`timescale 1ns / 1ps
`default_nettype none
// Keeps a table of counts and saturating sums for each of 512 groups.
// An accumulate transfer adds one record to its group and returns nothing;
// a read transfer returns the group's counts, the delay rate in percent and
// the Q8 means (zero where the divisor count is zero). Items land in a
// four-deep queue and are worked off one at a time by the back end, which
// owns the group RAM. After reset the back end clears the RAM,
// one row per cycle; full is held high during that pass.
// An accumulate occupies the back end for a queue pop, a RAM read and a
// RAM write. A read also occupies it while the bit-serial divider
// forms the five averages in turn.
// A finished result waits in the output register while the next items are
// accepted and worked on.
module grouped_sum_and_average (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output      logic          full,
  input  wire gsa_pkg::in_t  in_data_i,
  output      logic          empty,
  input  wire logic          pop,
  output      gsa_pkg::out_t out_data_o
);
  logic         q_full, q_valid, q_pop, clearing;
  gsa_pkg::in_t q_data;

  assign full = q_full | clearing;

  gsa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push & ~full),
    .data_i  (in_data_i),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  gsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_data),
    .item_pop_o   (q_pop),
    .clearing_o   (clearing),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_o        (out_data_o)
  );

  // no transfer in while the table is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full) else $error("input open during table clear");

  // the back end does not take an item before the clear pass is over
  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !q_pop) else $error("item taken during table clear");

  // delayed records are a subset of all records
  a_delayed_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.delayed_total <= out_data_o.record_total))
    else $error("delayed count above record count");

  // an empty group reports a zero delay rate and a zero mean wind
  a_empty_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.record_total == 32'd0) |->
      (out_data_o.delay_rate_q8 == 15'd0 && out_data_o.avg_wind_q8 == 19'd0))
    else $error("nonzero average for empty group");
endmodule
`default_nettype wire
